// ===== rtl/jli_pkg.sv =====
// package: payload types and register codes of the joint loopback integrator
`default_nettype none
package jli_pkg;

  localparam int CMD_W  = 32;
  localparam int TIME_W = 48;
  localparam int PER_W  = 31;
  localparam int DT_W   = TIME_W + 1;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_JOINT_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MODE_MAP    = 2'd1;

  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_VEL = 2'd1;
  localparam logic [1:0] MODE_EFF = 2'd2;

  localparam logic [3:0]  JOINT_COUNT_RST = 4'd3;
  localparam logic [15:0] MODE_MAP_RST    = 16'd21;

  typedef struct packed {
    logic [2:0]              joint;
    logic signed [CMD_W-1:0] command;
    logic signed [CMD_W-1:0] desired_command;
    logic [TIME_W-1:0]       time_now;
    logic [PER_W-1:0]        period;
    logic                    end_of_tick;
  } in_t;

  typedef struct packed {
    logic [2:0]              joint_out;
    logic signed [CMD_W-1:0] position;
    logic signed [CMD_W-1:0] velocity;
    logic signed [CMD_W-1:0] effort;
    logic signed [CMD_W-1:0] desired_relay;
    logic [1:0]              mode_out;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/joint_loopback_integrator_unit.sv =====
// top level: joint loopback integrator with one bit-serial divide/multiply unit
// each item passes S_SETUP, then S_LOAD, S_RUN and S_DONE for each step, then S_FIN to out_valid
// position mode runs two divides, velocity a multiply and a divide, effort two multiplies, an unused mode none
// one item at a time, next one taken once the last has left S_FIN; divider, multiplier and output stalls set the rate
// a zero step or an unused joint goes from S_SETUP back to S_IDLE with no result
// synchronous reset clears joint state and last tick time, sets joint_count 3, mode_map 21
`default_nettype none
module joint_loopback_integrator_unit #(
  parameter int MAX_JOINTS    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire jli_pkg::in_t             in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output jli_pkg::out_t                 out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [jli_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [15:0]              cfg_data
);
  import jli_pkg::*;

  localparam int JW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int NW   = CMD_W + 1 + FRACTION_BITS;
  localparam int AW   = CMD_W + DT_W;
  localparam int QW   = AW - FRACTION_BITS;
  localparam int CW   = $clog2(NW + 1);
  localparam int CAPW = 35;
  localparam logic [QW-1:0] CAP = QW'(64'd1 << 34);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_LOAD  = 6'b000100,
    S_RUN   = 6'b001000,
    S_DONE  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;

  logic [3:0]  joint_count;
  logic [15:0] mode_map;
  logic signed [CMD_W-1:0] joint_position [MAX_JOINTS];
  logic signed [CMD_W-1:0] joint_velocity [MAX_JOINTS];
  logic signed [CMD_W-1:0] joint_effort   [MAX_JOINTS];
  logic signed [CMD_W-1:0] last_command   [MAX_JOINTS];
  logic [TIME_W-1:0]       last_tick_time;

  in_t              item;
  logic [JW-1:0]    jidx;
  logic [1:0]       mode;
  logic             step;
  logic [DT_W-1:0]  dmag;
  logic             dneg;
  logic signed [CMD_W-1:0] r_p, r_v, r_e, prev, pv;

  logic [CW-1:0]    cnt;
  logic             is_div, neg;
  logic [NW-1:0]    quo;
  logic [DT_W:0]    rem;
  logic [AW-1:0]    acc, breg;
  logic [CMD_W-1:0] amag;
  logic signed [CMD_W-1:0] xreg;

  // setup values
  logic [DT_W-1:0] dt;
  logic            in_use;
  always_comb begin
    if (last_tick_time == '0) dt = DT_W'(item.period);
    else dt = {1'b0, item.time_now} - {1'b0, last_tick_time};
    in_use = ({1'b0, item.joint} < joint_count) && (32'(item.joint) < MAX_JOINTS);
  end

  // operand selection for the current step
  logic                    op_div;
  logic signed [CMD_W:0]   op_diff;
  logic signed [CMD_W-1:0] op_v, op_x;
  always_comb begin
    op_div  = 1'b1;
    op_diff = (CMD_W+1)'(item.command) - (CMD_W+1)'(prev);
    op_v    = item.command;
    op_x    = r_p;
    case (mode)
      MODE_POS: begin
        if (step) op_diff = (CMD_W+1)'(r_v) - (CMD_W+1)'(pv);
      end
      MODE_VEL: begin
        op_div = step;
      end
      MODE_EFF: begin
        op_div = 1'b0;
        if (!step) op_x = r_v;
        else op_v = r_v;
      end
      default: begin
        op_div = 1'b1;
      end
    endcase
  end

  // one restoring divide step
  logic [DT_W:0] rem_sh;
  logic          ge;
  always_comb begin
    rem_sh = {rem[DT_W-1:0], quo[NW-1]};
    ge     = rem_sh >= {1'b0, dmag};
  end

  // result of the finished operation
  logic signed [CMD_W-1:0] div_res, mul_res;
  logic [QW-1:0]           q;
  logic [CAPW-1:0]         qc;
  logic signed [CAPW+1:0]  sum;
  always_comb begin
    if (!neg) begin
      if (quo > NW'(32'h7fffffff)) div_res = 32'sh7fffffff;
      else div_res = signed'(quo[CMD_W-1:0]);
    end else begin
      if (quo > NW'(33'h080000000)) div_res = 32'sh80000000;
      else div_res = signed'(~quo[CMD_W-1:0] + 32'd1);
    end
    q  = acc[AW-1:FRACTION_BITS];
    qc = (q > CAP) ? CAPW'(CAP) : q[CAPW-1:0];
    if (neg) sum = (CAPW+2)'(xreg) - signed'({2'b0, qc});
    else sum = (CAPW+2)'(xreg) + signed'({2'b0, qc});
    if (sum > (CAPW+2)'(32'sh7fffffff)) mul_res = 32'sh7fffffff;
    else if (sum < (CAPW+2)'(32'sh80000000)) mul_res = 32'sh80000000;
    else mul_res = sum[CMD_W-1:0];
  end

  logic signed [CMD_W-1:0] op_res;
  assign op_res = is_div ? div_res : mul_res;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      joint_count    <= JOINT_COUNT_RST;
      mode_map       <= MODE_MAP_RST;
      last_tick_time <= '0;
      for (int i = 0; i < MAX_JOINTS; i++) begin
        joint_position[i] <= '0;
        joint_velocity[i] <= '0;
        joint_effort[i]   <= '0;
        last_command[i]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_JOINT_COUNT: joint_count <= cfg_data[3:0];
          CFG_MODE_MAP:    mode_map <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          jidx <= JW'(item.joint);
          mode <= mode_map[{item.joint, 1'b0} +: 2];
          step <= 1'b0;
          dmag <= dt[DT_W-1] ? -dt : dt;
          dneg <= dt[DT_W-1];
          r_p  <= joint_position[JW'(item.joint)];
          r_v  <= joint_velocity[JW'(item.joint)];
          r_e  <= joint_effort[JW'(item.joint)];
          pv   <= joint_velocity[JW'(item.joint)];
          prev <= last_command[JW'(item.joint)];
          if (dt == '0) begin
            state <= S_IDLE;
          end else begin
            if (item.end_of_tick) last_tick_time <= item.time_now;
            if (!in_use) begin
              state <= S_IDLE;
            end else begin
              case (mode_map[{item.joint, 1'b0} +: 2])
                MODE_POS: begin
                  r_p   <= item.command;
                  state <= S_LOAD;
                end
                MODE_VEL: begin
                  r_v   <= item.command;
                  state <= S_LOAD;
                end
                MODE_EFF: begin
                  r_e   <= item.command;
                  state <= S_LOAD;
                end
                default: state <= S_FIN;
              endcase
            end
          end
        end
        S_LOAD: begin
          is_div <= op_div;
          rem    <= '0;
          acc    <= '0;
          xreg   <= op_x;
          if (op_div) begin
            quo <= {(op_diff[CMD_W] ? -op_diff : op_diff), {FRACTION_BITS{1'b0}}};
            neg <= op_diff[CMD_W] ^ dneg;
            cnt <= CW'(NW);
          end else begin
            amag <= op_v[CMD_W-1] ? -op_v : op_v;
            breg <= AW'(dmag);
            neg  <= op_v[CMD_W-1] ^ dneg;
            cnt  <= CW'(CMD_W);
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (is_div) begin
            rem <= ge ? rem_sh - {1'b0, dmag} : rem_sh;
            quo <= {quo[NW-2:0], ge};
          end else begin
            if (amag[0]) acc <= acc + breg;
            amag <= amag >> 1;
            breg <= breg << 1;
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) state <= S_DONE;
        end
        S_DONE: begin
          case (mode)
            MODE_POS: begin
              if (step) r_e <= op_res;
              else r_v <= op_res;
            end
            MODE_VEL: begin
              if (step) r_e <= op_res;
              else r_p <= op_res;
            end
            default: begin
              if (step) r_p <= op_res;
              else r_v <= op_res;
            end
          endcase
          step  <= 1'b1;
          state <= step ? S_FIN : S_LOAD;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            joint_position[jidx] <= r_p;
            joint_velocity[jidx] <= r_v;
            joint_effort[jidx]   <= r_e;
            last_command[jidx]   <= item.command;
            out_data.joint_out     <= item.joint;
            out_data.position      <= r_p;
            out_data.velocity      <= r_v;
            out_data.effort        <= r_e;
            out_data.desired_relay <= (mode == MODE_POS || mode == MODE_VEL ||
                                       mode == MODE_EFF) ? item.desired_command : '0;
            out_data.mode_out      <= mode;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_unused_mode_no_relay: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode_out == 2'd3 |-> out_data.desired_relay == '0)
    else $error("relay not cleared for an unused mode");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> cnt != '0 && cnt <= CW'(NW))
    else $error("iteration counter out of range");
`endif

endmodule
`default_nettype wire

// ===== test/tb_joint_loopback_integrator_unit.sv =====
// testbench: joint loopback integrator checked against an in-bench predictor with random stimulus
`timescale 1ns / 100ps
`default_nettype none
module tb_joint_loopback_integrator_unit;
  import jli_pkg::*;

  localparam int NJ = 8;
  localparam int FB = 16;
  localparam logic signed [63:0] MAG_LIMIT = 64'sd1 << 34;

  class joint_scoreboard;
    logic [3:0]         joints_used;
    logic [15:0]        modes;
    logic signed [31:0] pos [NJ];
    logic signed [31:0] vel [NJ];
    logic signed [31:0] eff [NJ];
    logic signed [31:0] prev_cmd [NJ];
    logic [47:0]        tick_time;
    out_t               pending [$];
    int                 mismatches;
    int                 results_seen;

    function new();
      joints_used = JOINT_COUNT_RST;
      modes = MODE_MAP_RST;
      tick_time = '0;
      mismatches = 0;
      results_seen = 0;
      for (int i = 0; i < NJ; i++) begin
        pos[i] = 0; vel[i] = 0; eff[i] = 0; prev_cmd[i] = 0;
      end
    endfunction

    function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] slope(logic signed [31:0] a, logic signed [31:0] b,
                                       logic signed [63:0] dt);
      logic signed [63:0] num;
      num = (64'(a) - 64'(b)) <<< FB;
      return clamp32(num / dt);
    endfunction

    function logic signed [31:0] accumulate(logic signed [31:0] x, logic signed [31:0] v,
                                            logic signed [63:0] dt);
      logic neg;
      logic [63:0] a, b, hi, lo, q;
      neg = (v < 0) != (dt < 0);
      a = (v < 0) ? 64'(-64'(v)) : 64'(v);
      b = (dt < 0) ? 64'(-dt) : 64'(dt);
      hi = a * (b >> 24);
      lo = (a * (b & 64'hffffff)) >> FB;
      if (hi >= 64'(MAG_LIMIT)) q = 64'(MAG_LIMIT);
      else begin
        q = (hi << (24 - FB)) + lo;
        if (q > 64'(MAG_LIMIT)) q = 64'(MAG_LIMIT);
      end
      return clamp32(64'(x) + (neg ? -$signed(q) : $signed(q)));
    endfunction

    function void note_input(in_t it);
      logic signed [63:0] dt;
      logic signed [31:0] pv, cmd;
      logic [1:0] md;
      int j;
      out_t r;
      j = int'(it.joint);
      cmd = it.command;
      if (tick_time == 0) dt = 64'(it.period);
      else dt = $signed({16'd0, it.time_now}) - $signed({16'd0, tick_time});
      if (dt == 0) return;
      if (j < joints_used) begin
        md = modes[2*j +: 2];
        r.desired_relay = it.desired_command;
        case (md)
          MODE_POS: begin
            pv = vel[j];
            pos[j] = cmd;
            vel[j] = slope(cmd, prev_cmd[j], dt);
            eff[j] = slope(vel[j], pv, dt);
          end
          MODE_VEL: begin
            pos[j] = accumulate(pos[j], cmd, dt);
            vel[j] = cmd;
            eff[j] = slope(cmd, prev_cmd[j], dt);
          end
          MODE_EFF: begin
            eff[j] = cmd;
            vel[j] = accumulate(vel[j], cmd, dt);
            pos[j] = accumulate(pos[j], vel[j], dt);
          end
          default: r.desired_relay = '0;
        endcase
        prev_cmd[j] = cmd;
        r.joint_out = it.joint;
        r.position = pos[j];
        r.velocity = vel[j];
        r.effort = eff[j];
        r.mode_out = md;
        pending.insert(pending.size(), r);
      end
      if (it.end_of_tick) tick_time = it.time_now;
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.joint_out !== want.joint_out || got.position !== want.position ||
          got.velocity !== want.velocity || got.effort !== want.effort ||
          got.desired_relay !== want.desired_relay || got.mode_out !== want.mode_out) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  joint_scoreboard board = new();
  int items_sent = 0;
  bit hold_off = 0;
  logic [47:0] clock_now = 48'h10000;

  always #2 clk = ~clk;

  joint_loopback_integrator_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    if (rst || hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 3) != 0) || (items_sent[8:6] == 3'd2);
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_JOINT_COUNT) board.joints_used = val[3:0];
    else board.modes = val;
    @(posedge clk);
  endtask

  task automatic settle();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send(in_t it);
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
    items_sent++;
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_gap(in_t it);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 12)) @(posedge clk);
    send(it);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 300000)) :
                -32'($urandom_range(0, 300000));
      default: return $urandom;
    endcase
  endfunction

  // one tick of items over joints 0 to 5 and random joints, mostly advancing time
  task automatic run_tick();
    in_t it;
    int n;
    logic [47:0] step;
    n = $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0: step = 48'({$urandom, $urandom});
      1: step = -48'($urandom_range(1, 5000));
      2: step = 48'd0;
      default: step = 48'($urandom_range(1, 1 << 17));
    endcase
    clock_now = clock_now + step;
    for (int k = 0; k < n; k++) begin
      it.joint = (k < 6) ? 3'(k) : 3'($urandom);
      it.command = pick32();
      it.desired_command = $urandom;
      it.time_now = ($urandom_range(0, 30) == 0) ? 48'({$urandom, $urandom}) : clock_now;
      it.period = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'h666;
      it.end_of_tick = (k == n - 1) || ($urandom_range(0, 15) == 0);
      send_gap(it);
    end
  endtask

  initial begin
    in_t it;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first step from period, field extremes, zero step, unused joint
    it = '0;
    it.period = 31'h7fffffff;
    it.time_now = 48'hffff_ffff_ffff;
    it.command = 32'h7fffffff;
    it.desired_command = 32'h80000000;
    send(it);
    it.joint = 3'd1; it.command = 32'h80000000; it.desired_command = 32'h7fffffff; send(it);
    it.joint = 3'd2; it.end_of_tick = 1'b1; send(it);
    it.joint = 3'd0; it.period = 31'd1; it.end_of_tick = 1'b0; send(it); // zero step
    it.time_now = 48'd0; it.joint = 3'd7; it.command = 32'd65536; send(it);
    it.joint = 3'd3; it.time_now = 48'd1; send(it);
    it.joint = 3'd0; it.time_now = 48'h8000_0000_0000; it.end_of_tick = 1'b1; send(it);
    it.joint = 3'd1; it.time_now = 48'd5; it.command = -32'sd1; send(it);
    settle();
    write_reg(CFG_MODE_MAP, 16'hffff);
    write_reg(CFG_JOINT_COUNT, 4'd8);
    for (int k = 0; k < 8; k++) begin
      it.joint = 3'(k); it.command = 32'($urandom); it.time_now = 48'd9 + k;
      it.end_of_tick = 1'b1; send(it);
    end
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CFG_JOINT_COUNT, 4'd8); write_reg(CFG_MODE_MAP, 16'h0000); end
        1: write_reg(CFG_MODE_MAP, 16'h5555);
        2: write_reg(CFG_MODE_MAP, 16'haaaa);
        3: begin write_reg(CFG_JOINT_COUNT, 4'd0); write_reg(CFG_MODE_MAP, 16'he4e4); end
        4: begin write_reg(CFG_JOINT_COUNT, 4'hf); write_reg(CFG_MODE_MAP, 16'($urandom)); end
        default: begin
          write_reg(CFG_JOINT_COUNT, 4'($urandom_range(1, 8)));
          write_reg(CFG_MODE_MAP, 16'($urandom) & 16'h7777 | 16'h0001);
        end
      endcase
      while (items_sent < 30 + (phase + 1) * 228) begin
        run_tick();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      settle();
    end

    $display("run covered %0d input transactions and %0d results over all joint modes",
             items_sent, board.results_seen);
    $display("register settings included zero, full and out-of-range joint counts");
    if (board.mismatches == 0 && board.pending.size() == 0) $display("All tests passed");
    else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end

  // long receiver hold-off while the sender keeps offering transactions
  initial begin
    wait (items_sent > 400);
    @(posedge clk);
    hold_off <= 1;
    repeat (1500) @(posedge clk);
    hold_off <= 0;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
